[rtl/b2da_pkg.sv]
// Shared constants and types for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int unsigned VALUE_BITS_DEFAULT = 32;
  localparam int unsigned FIELD_BITS         = 32;
  localparam int unsigned DIGIT_CODE_BITS    = 6;
  localparam int unsigned DIGIT_BITS         = 4;
  localparam int unsigned MAX_DIGITS         = 10;
  localparam int unsigned BCD_BITS           = MAX_DIGITS * DIGIT_BITS;
  localparam int unsigned REM_W              = $clog2(MAX_DIGITS + 1);

  localparam logic [DIGIT_CODE_BITS-1:0] ASCII_ZERO = DIGIT_CODE_BITS'(48);
  localparam logic [DIGIT_BITS-1:0]      DABBLE_LIMIT = DIGIT_BITS'(5);
  localparam logic [DIGIT_BITS-1:0]      DABBLE_ADJ   = DIGIT_BITS'(3);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

[rtl/binary_to_decimal_ascii_top.sv]
// Top level of the binary to decimal ASCII converter.
//
// Input channel: value_i with valid_i/ready_o. One beat carries an unsigned
// number; only its low VALUE_BITS bits (at most the 32-bit field) count.
// Output channel: digit_code_o/last_digit_o with valid_o/ready_i. One beat per
// decimal digit, most significant first, leading zeros dropped; zero gives a
// single '0'. last_digit_o marks the final digit of a value.
// Sequence: a load step, then one shift-add-3 step through the shared dabble
// unit for each of the min(VALUE_BITS,32) converted bits, then a scan over the
// ten digit positions, emitting one digit or skipping one leading zero per step.
// ready_o is high only while idle; a new value may be taken while the last
// digit of the previous one still waits in the output register.
// A receiver stall holds the output register and the scan at a digit to emit.
// Reset empties the output register and returns the sequencer to idle.
module binary_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [b2da_pkg::FIELD_BITS-1:0]      value_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [b2da_pkg::DIGIT_CODE_BITS-1:0] digit_code_o,
  output logic                                 last_digit_o
);

  localparam int unsigned CONV_BITS =
    (VALUE_BITS < b2da_pkg::FIELD_BITS) ? VALUE_BITS : b2da_pkg::FIELD_BITS;
  localparam int unsigned CNT_W = $clog2(CONV_BITS + 1);

  b2da_pkg::state_e state_q, state_d;

  logic [CONV_BITS-1:0]               bin_q, bin_d;
  logic [b2da_pkg::BCD_BITS-1:0]      bcd_q, bcd_d, bcd_step;
  logic [CNT_W-1:0]                   cnt_q, cnt_d;
  logic [b2da_pkg::REM_W-1:0]         rem_q, rem_d;
  logic                               started_q, started_d;
  logic                               out_valid_q, out_valid_d;
  logic [b2da_pkg::DIGIT_CODE_BITS-1:0] code_q, code_d;
  logic                               last_q, last_d;
  logic [b2da_pkg::DIGIT_BITS-1:0]    top_digit;
  logic                               skip;
  logic                               slot_free;

  b2da_dabble_unit u_dabble (
    .bcd_i (bcd_q),
    .bit_i (bin_q[CONV_BITS-1]),
    .bcd_o (bcd_step)
  );

  assign top_digit = bcd_q[b2da_pkg::BCD_BITS-1 -: b2da_pkg::DIGIT_BITS];
  assign skip      = !started_q && (top_digit == '0) && (rem_q != b2da_pkg::REM_W'(1));
  assign slot_free = !out_valid_q || ready_i;

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && !ready_i;
    code_d      = code_q;
    last_d      = last_q;

    case (state_q)
      b2da_pkg::ST_IDLE: begin
        if (valid_i) begin
          bin_d     = value_i[CONV_BITS-1:0];
          bcd_d     = '0;
          cnt_d     = CNT_W'(CONV_BITS);
          rem_d     = b2da_pkg::REM_W'(b2da_pkg::MAX_DIGITS);
          started_d = 1'b0;
          state_d   = b2da_pkg::ST_CONV;
        end
      end
      b2da_pkg::ST_CONV: begin
        bcd_d = bcd_step;
        bin_d = bin_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = b2da_pkg::ST_EMIT;
        end
      end
      b2da_pkg::ST_EMIT: begin
        if (skip) begin
          bcd_d = bcd_q << b2da_pkg::DIGIT_BITS;
          rem_d = rem_q - b2da_pkg::REM_W'(1);
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          code_d      = b2da_pkg::ASCII_ZERO + b2da_pkg::DIGIT_CODE_BITS'(top_digit);
          last_d      = (rem_q == b2da_pkg::REM_W'(1));
          started_d   = 1'b1;
          bcd_d       = bcd_q << b2da_pkg::DIGIT_BITS;
          rem_d       = rem_q - b2da_pkg::REM_W'(1);
          if (rem_q == b2da_pkg::REM_W'(1)) begin
            state_d = b2da_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = b2da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= b2da_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      started_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      started_q   <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  assign ready_o      = (state_q == b2da_pkg::ST_IDLE);
  assign valid_o      = out_valid_q;
  assign digit_code_o = code_q;
  assign last_digit_o = last_q;

endmodule

[rtl/b2da_dabble_unit.sv]
// One shift-add-3 step: correct every BCD digit, then shift in the next binary bit.
module b2da_dabble_unit (
  input  logic [b2da_pkg::BCD_BITS-1:0] bcd_i,
  input  logic                          bit_i,
  output logic [b2da_pkg::BCD_BITS-1:0] bcd_o
);

  logic [b2da_pkg::BCD_BITS-1:0] adj;

  always_comb begin
    for (int i = 0; i < int'(b2da_pkg::MAX_DIGITS); i++) begin
      if (bcd_i[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] >= b2da_pkg::DABBLE_LIMIT) begin
        adj[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] =
          bcd_i[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] + b2da_pkg::DABBLE_ADJ;
      end else begin
        adj[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] =
          bcd_i[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS];
      end
    end
  end

  assign bcd_o = {adj[b2da_pkg::BCD_BITS-2:0], bit_i};

endmodule

[rtl/b2da_checker.sv]
// Port-level checks for the binary to decimal ASCII converter, bound to the top level.
module b2da_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 valid_i,
  input logic                                 ready_o,
  input logic                                 valid_o,
  input logic                                 ready_i,
  input logic [b2da_pkg::DIGIT_CODE_BITS-1:0] digit_code_o,
  input logic                                 last_digit_o
);

  logic first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (valid_o && ready_i) begin
      first_q <= last_digit_o;
    end
  end

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (digit_code_o >= b2da_pkg::ASCII_ZERO) &&
                (digit_code_o <= b2da_pkg::ASCII_ZERO + b2da_pkg::DIGIT_CODE_BITS'(9)))
    else $error("digit code outside '0'..'9'");

  a_no_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && first_q && !last_digit_o) |-> (digit_code_o != b2da_pkg::ASCII_ZERO))
    else $error("leading zero emitted");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> !ready_o)
    else $error("ready held after input beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o && $stable(digit_code_o) && $stable(last_digit_o))
    else $error("stalled output beat changed");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (valid_i),
  .ready_o      (ready_o),
  .valid_o      (valid_o),
  .ready_i      (ready_i),
  .digit_code_o (digit_code_o),
  .last_digit_o (last_digit_o)
);

[sim/tb.sv]
// Self-checking testbench for the binary to decimal ASCII converter.
module tb;

  typedef struct packed {
    logic [b2da_pkg::DIGIT_CODE_BITS-1:0] code;
    logic                                 last;
  } digit_beat_t;

  typedef struct packed {
    logic [b2da_pkg::FIELD_BITS-1:0] value;
    logic [79:0]                     text;
  } number_row_t;

  localparam int unsigned ROWS        = 21;
  localparam int unsigned RAND_ITEMS  = 189;
  localparam int unsigned DRAIN_WAIT  = 60;

  localparam number_row_t NUMBER_TABLE [ROWS] = '{
    '{32'd0,          "0"},
    '{32'd1,          80'd0},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'd11,         80'd0},
    '{32'd99,         80'd0},
    '{32'd100,        80'd0},
    '{32'd255,        80'd0},
    '{32'd65535,      80'd0},
    '{32'd65536,      80'd0},
    '{32'd99999,      80'd0},
    '{32'd123456789,  80'd0},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{32'h7FFFFFFF,   80'd0},
    '{32'h80000000,   80'd0},
    '{32'h55555555,   80'd0},
    '{32'hAAAAAAAA,   80'd0},
    '{32'h0F0F0F0F,   80'd0},
    '{32'hFFFFFFFE,   80'd0},
    '{32'hFFFFFFFF,   "4294967295"}
  };

  logic                                 clk_i   = 1'b0;
  logic                                 rst_ni  = 1'b0;
  logic                                 valid_i = 1'b0;
  logic [b2da_pkg::FIELD_BITS-1:0]      value_i = '0;
  logic                                 ready_i = 1'b1;
  logic                                 ready_o;
  logic                                 valid_o;
  logic [b2da_pkg::DIGIT_CODE_BITS-1:0] digit_code_o;
  logic                                 last_digit_o;

  digit_beat_t expected_digits_q [$];
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_cycles = 0;

  binary_to_decimal_ascii_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .ready_o      (ready_o),
    .value_i      (value_i),
    .valid_o      (valid_o),
    .ready_i      (ready_i),
    .digit_code_o (digit_code_o),
    .last_digit_o (last_digit_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic push_predicted_digits(input logic [b2da_pkg::FIELD_BITS-1:0] number);
    logic [63:0]    rest;
    logic [3:0]     rev [b2da_pkg::MAX_DIGITS];
    int unsigned    count;
    digit_beat_t    beat;
    rest  = 64'(number);
    if (b2da_pkg::VALUE_BITS_DEFAULT < 64) begin
      rest = rest & ((64'd1 << b2da_pkg::VALUE_BITS_DEFAULT) - 64'd1);
    end
    count = 0;
    do begin
      rev[count] = 4'(rest % 64'd10);
      rest       = rest / 64'd10;
      count++;
    end while (rest != 0 && count < b2da_pkg::MAX_DIGITS);
    for (int k = int'(count) - 1; k >= 0; k--) begin
      beat.code = b2da_pkg::ASCII_ZERO + b2da_pkg::DIGIT_CODE_BITS'(rev[k]);
      beat.last = (k == 0);
      expected_digits_q.push_back(beat);
    end
  endtask

  task automatic send_value(input logic [b2da_pkg::FIELD_BITS-1:0] number);
    if (burst_left == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
      burst_left = $urandom_range(1, 6);
    end
    valid_i <= 1'b1;
    value_i <= number;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  initial begin
    logic [63:0]  tenpow;
    logic [31:0]  number;
    int unsigned  nchar;
    digit_beat_t  beat;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (NUMBER_TABLE[r]) begin
      send_value(NUMBER_TABLE[r].value);
      if (NUMBER_TABLE[r].text == 80'd0) begin
        push_predicted_digits(NUMBER_TABLE[r].value);
      end else begin
        nchar = 0;
        while (nchar < 10 && NUMBER_TABLE[r].text[8*nchar +: 8] != 8'd0) nchar++;
        for (int k = int'(nchar) - 1; k >= 0; k--) begin
          beat.code = NUMBER_TABLE[r].text[8*k +: b2da_pkg::DIGIT_CODE_BITS];
          beat.last = (k == 0);
          expected_digits_q.push_back(beat);
        end
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      tenpow = 64'd1;
      repeat ($urandom_range(1, 9)) tenpow = tenpow * 64'd10;
      case ($urandom_range(0, 3))
        0: number = $urandom;
        1: number = $urandom_range(0, 9);
        2: number = $urandom_range(0, 32'(tenpow - 64'd1));
        default: number = 32'(tenpow) + $urandom_range(0, 2) - 32'd1;
      endcase
      send_value(number);
      push_predicted_digits(number);
    end
    valid_i <= 1'b0;

    while (expected_digits_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && expected_digits_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hold a stall level for a stretch, then move to another one
  always @(posedge clk_i) begin
    if (stall_cycles == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 90;
      endcase
      stall_cycles = $urandom_range(16, 96);
    end
    stall_cycles--;
    ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    digit_beat_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (expected_digits_q.size() == 0) begin
        $error("unexpected digit beat: digit_code %0d last_digit %0b",
               digit_code_o, last_digit_o);
        errors++;
      end else begin
        want = expected_digits_q.pop_front();
        if (digit_code_o !== want.code) begin
          $error("digit_code: expected %0d, actual %0d", want.code, digit_code_o);
          errors++;
        end
        if (last_digit_o !== want.last) begin
          $error("last_digit: expected %0b, actual %0b", want.last, last_digit_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
